### rtl/ubds_pkg.sv
// Shared types and constants for the UART baud divisor selector.
// Depends on nothing; the divider step, lane and top files import it.
package ubds_pkg;

	localparam int QW = 17;   // quotient bits; anything above 65536 fails
	localparam int NW = 33;   // numerator width, clock plus half a period
	localparam int DW = 29;   // denominator width, up to 16 times the baud
	localparam int CW = DW + QW; // width of a shifted denominator

	localparam logic [1:0] MODE_ASYNC = 2'd0;
	localparam logic [1:0] MODE_SYNC_M = 2'd1;
	localparam logic [1:0] MODE_SYNC_S = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOL = 2'd1;
	localparam logic [1:0] ST_MODE = 2'd2;

	// Prepared operands for one divisor attempt.
	typedef struct packed {
		logic valid;
		logic [1:0] mode;
		logic zero;
		logic [NW-1:0] num;
		logic [DW-1:0] den;
		logic [2:0] fsh;
		logic [31:0] mhi;
		logic [31:0] mlo;
		logic chk_lo;
	} prep_t;

	// Payload that walks down the divider stages.
	typedef struct packed {
		logic valid;
		logic [1:0] mode;
		logic bad;
		logic [NW-1:0] rem;
		logic [DW-1:0] den;
		logic [QW-1:0] q;
		logic [2:0] fsh;
		logic [31:0] mhi;
		logic [31:0] mlo;
		logic chk_lo;
	} div_t;

	// Outcome of one attempt.
	typedef struct packed {
		logic valid;
		logic [1:0] mode;
		logic ok;
		logic [15:0] div;
	} lane_t;

endpackage

### rtl/ubds_req_if.sv
// Request channel: baud rate, tolerance and mode under valid/ready.
// Depends on nothing.
interface ubds_req_if;
	logic valid;
	logic ready;
	logic [23:0] baud_rate;
	logic [6:0] tolerance_percent;
	logic [1:0] opcode;
	modport source(output valid, baud_rate, tolerance_percent, opcode, input ready);
	modport sink(input valid, baud_rate, tolerance_percent, opcode, output ready);
endinterface

### rtl/ubds_rsp_if.sv
// Response channel: divisor, double-speed flag and status under valid/ready.
// Depends on nothing.
interface ubds_rsp_if;
	logic valid;
	logic ready;
	logic [15:0] divisor;
	logic double_speed;
	logic [1:0] status;
	modport source(output valid, divisor, double_speed, status, input ready);
	modport sink(input valid, divisor, double_speed, status, output ready);
endinterface

### rtl/ubds_div_step.sv
// One registered restoring-division step, settling quotient bit K.
// Depends on ubds_pkg.
module ubds_div_step #(
	parameter int K = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input ubds_pkg::div_t d_i,
	output ubds_pkg::div_t d_o
);
	import ubds_pkg::*;

	logic [CW-1:0] sh;
	logic take;
	div_t nxt;

	// Trial subtraction of the denominator shifted to this bit.
	always_comb begin
		sh = {{QW{1'b0}}, d_i.den} << K;
		take = {{(CW-NW){1'b0}}, d_i.rem} >= sh;
		nxt = d_i;
		if (take) begin
			nxt.rem = d_i.rem - sh[NW-1:0];
			nxt.q[K] = 1'b1;
		end
	end

	// Stage register; only the valid bit is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_o.valid <= 1'b0;
		end else if (en) begin
			d_o <= nxt;
		end
	end
endmodule

### rtl/ubds_lane.sv
// One divisor attempt: overflow check, 17 division steps, rate check.
// Depends on ubds_pkg and ubds_div_step.
module ubds_lane (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [31:0] clock_hz,
	input ubds_pkg::prep_t p_i,
	output ubds_pkg::lane_t r_o
);
	import ubds_pkg::*;

	div_t st [QW+1];
	logic [CW-1:0] lim;
	logic [QW-1:0] q_f;
	logic [20:0] ticks;
	logic bad_q;
	logic v_s20, lo_s20, bad_s20;
	logic [1:0] mode_s20;
	logic [15:0] div_s20;
	logic [52:0] up_s20, low_s20;
	logic [38:0] scaled;

	// Entry stage: a zero baud rate, or a quotient of 2^17 or more, fails at once.
	assign lim = {{QW{1'b0}}, p_i.den} << QW;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st[0].valid <= 1'b0;
		end else if (en) begin
			st[0].valid <= p_i.valid;
			st[0].mode <= p_i.mode;
			st[0].bad <= p_i.zero || ({{(CW-NW){1'b0}}, p_i.num} >= lim);
			st[0].rem <= p_i.num;
			st[0].den <= p_i.den;
			st[0].q <= '0;
			st[0].fsh <= p_i.fsh;
			st[0].mhi <= p_i.mhi;
			st[0].mlo <= p_i.mlo;
			st[0].chk_lo <= p_i.chk_lo;
		end
	end

	// Division steps, most significant quotient bit first.
	for (genvar i = 0; i < QW; i++) begin : g_step
		ubds_div_step #(.K(QW-1-i)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en), .d_i(st[i]), .d_o(st[i+1])
		);
	end

	// Product stage: period in clocks times the rate bounds.
	assign q_f = st[QW].q;
	assign ticks = {4'd0, q_f} << st[QW].fsh;
	assign bad_q = st[QW].bad || (q_f == '0) || (q_f[16] && (q_f[15:0] != 16'd0));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s20 <= 1'b0;
		end else if (en) begin
			v_s20 <= st[QW].valid;
			mode_s20 <= st[QW].mode;
			bad_s20 <= bad_q;
			lo_s20 <= st[QW].chk_lo;
			div_s20 <= 16'(q_f - 17'd1);
			up_s20 <= 53'(ticks) * 53'(st[QW].mhi);
			low_s20 <= 53'(ticks) * 53'(st[QW].mlo);
		end
	end

	// Compare stage against the scaled clock.
	assign scaled = 39'(clock_hz) * 39'd100;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_o.valid <= 1'b0;
		end else if (en) begin
			r_o.valid <= v_s20;
			r_o.mode <= mode_s20;
			r_o.div <= div_s20;
			r_o.ok <= !bad_s20 && !(53'(scaled) > up_s20)
				&& !(lo_s20 && (53'(scaled) < low_s20));
		end
	end
endmodule

### rtl/uart_baud_divisor_select_top.sv
// UART baud divisor selector: x16 (x2 in the synchronous modes) and x8 attempts side by side, then selection.
// One beat per cycle whenever the response slot is free or being taken.
// Each lane holds a 17-stage restoring divider.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and loads a clock of 16 MHz.
// Depends on ubds_pkg, ubds_req_if, ubds_rsp_if and ubds_lane.
module uart_baud_divisor_select_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	ubds_req_if.sink req,
	ubds_rsp_if.source rsp
);
	import ubds_pkg::*;

	logic [31:0] clock_hz_q;
	logic en;
	prep_t pa, pb, pa_s1, pb_s1;
	lane_t ra, rb;
	logic [31:0] mhi, mlo;
	logic [15:0] div_n;
	logic dbl_n;
	logic [1:0] st_n;

	// Clock register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= 32'd16000000;
		end else if (cfg_we) begin
			clock_hz_q <= cfg_wdata;
		end
	end

	// The pipeline moves whenever the response slot is free or being taken.
	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// Operand preparation for both attempts.
	always_comb begin
		mhi = 32'(req.baud_rate) * (32'd100 + 32'(req.tolerance_percent));
		mlo = 32'(req.baud_rate) * (32'd100 - 32'(req.tolerance_percent));
		pa.valid = req.valid;
		pa.mode = req.opcode;
		pa.zero = req.baud_rate == 24'd0;
		pa.mhi = mhi;
		pa.mlo = mlo;
		pa.chk_lo = req.tolerance_percent < 7'd100;
		if (req.opcode == MODE_ASYNC) begin
			pa.fsh = 3'd4;
			pa.num = NW'(clock_hz_q) + (NW'(req.baud_rate) << 3);
			pa.den = DW'(req.baud_rate) << 4;
		end else begin
			pa.fsh = 3'd1;
			pa.num = NW'(clock_hz_q) + NW'(req.baud_rate);
			pa.den = DW'(req.baud_rate) << 1;
		end
		pb = pa;
		pb.fsh = 3'd3;
		pb.num = NW'(clock_hz_q) + (NW'(req.baud_rate) << 2);
		pb.den = DW'(req.baud_rate) << 3;
	end

	// Preparation register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_s1.valid <= 1'b0;
			pb_s1.valid <= 1'b0;
		end else if (en) begin
			pa_s1 <= pa;
			pb_s1 <= pb;
		end
	end

	ubds_lane u_lane_a (
		.clk(clk), .arst_n(arst_n), .en(en), .clock_hz(clock_hz_q), .p_i(pa_s1), .r_o(ra)
	);
	ubds_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .en(en), .clock_hz(clock_hz_q), .p_i(pb_s1), .r_o(rb)
	);

	// Pick the first attempt that passes for the mode.
	always_comb begin
		div_n = 16'd0;
		dbl_n = 1'b0;
		st_n = ST_OK;
		unique case (ra.mode)
			MODE_ASYNC: begin
				if (ra.ok) begin
					div_n = ra.div;
				end else if (rb.ok) begin
					div_n = rb.div;
					dbl_n = 1'b1;
				end else begin
					st_n = ST_TOL;
				end
			end
			MODE_SYNC_M, MODE_SYNC_S: begin
				if (ra.ok) begin
					div_n = ra.div;
				end else begin
					st_n = ST_TOL;
				end
			end
			default: st_n = ST_MODE;
		endcase
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= ra.valid;
			rsp.divisor <= div_n;
			rsp.double_speed <= dbl_n;
			rsp.status <= st_n;
		end
	end
endmodule
